@@ design/lprd_pkg.sv @@
package lprd_pkg;

  localparam int NUM_W      = 32;
  localparam int MAX_DIGITS = 20;
  localparam int DIGIT_W    = 5;

  typedef logic [NUM_W-1:0]   num_t;
  typedef logic [DIGIT_W-1:0] digit_cnt_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COUNT,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  localparam logic [1:0] KIND_BYTE         = 2'd0;
  localparam logic [1:0] KIND_EMPTY_FIELD  = 2'd1;
  localparam logic [1:0] KIND_EMPTY_RECORD = 2'd2;
  localparam logic [1:0] KIND_ERROR        = 2'd3;

  localparam logic [2:0] ERR_EMPTY    = 3'd0;
  localparam logic [2:0] ERR_BADCHAR  = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_LIMIT    = 3'd3;
  localparam logic [2:0] ERR_TRUNC    = 3'd4;

  localparam logic [7:0] CHAR_PIPE  = 8'h7C;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    num_t       field_number;
    logic       last_of_field;
    logic       last_of_record;
    logic [2:0] error_code;
  } res_t;

endpackage

@@ design/lprd_in_if.sv @@
interface lprd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_data;

  modport source (output valid, output in_byte, output end_of_data, input ready);
  modport sink (input valid, input in_byte, input end_of_data, output ready);
endinterface

@@ design/lprd_out_if.sv @@
interface lprd_out_if;
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [7:0]       out_byte;
  lprd_pkg::num_t   field_number;
  logic             last_of_field;
  logic             last_of_record;
  logic [2:0]       error_code;

  modport source (output valid, output kind, output out_byte, output field_number,
                  output last_of_field, output last_of_record, output error_code,
                  input ready);
  modport sink (input valid, input kind, input out_byte, input field_number,
                input last_of_field, input last_of_record, input error_code,
                output ready);
endinterface

@@ design/lprd_out_buf.sv @@
// Two-entry result queue: two slots used as a ring, with a write and a read pointer.
module lprd_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lprd_pkg::res_t     push_data,
  output logic               full,
  lprd_out_if.source         out_stream
);

  lprd_pkg::res_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           pop;
  lprd_pkg::res_t head;

  assign full = (count == 2'd2);
  assign pop  = out_stream.valid && out_stream.ready;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign out_stream.valid          = (count != 2'd0);
  assign out_stream.kind           = head.kind;
  assign out_stream.out_byte       = head.out_byte;
  assign out_stream.field_number   = head.field_number;
  assign out_stream.last_of_field  = head.last_of_field;
  assign out_stream.last_of_record = head.last_of_record;
  assign out_stream.error_code     = head.error_code;

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full result queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("result queue count out of range");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 2'd1) else $error("queue count slip on pop");

endmodule

@@ design/length_prefixed_record_deframer_top.sv @@
// Channel     | Dir | Payload
// ------------+-----+-----------------------------------------------------------
// in_stream   | in  | in_byte[7:0], end_of_data
// out_stream  | out | kind[1:0], out_byte[7:0], field_number[31:0],
//             |     | last_of_field, last_of_record, error_code[2:0]
// cfg         | in  | cfg_we, cfg_wdata[31:0] (max_field_length)
//
// One byte per cycle while the queue has room: each request is parsed in the cycle
// it is taken and its result is registered into a two-entry output queue.
// in_stream.ready drops only while both queue entries are held by out_stream.
// Synchronous reset clears parse state, the queue and sets max length to all ones.
// After an error the block drops every request until reset.
module length_prefixed_record_deframer_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  lprd_pkg::num_t    cfg_wdata,
  lprd_in_if.sink           in_stream,
  lprd_out_if.source        out_stream
);

  lprd_pkg::num_t       max_field_length;
  lprd_pkg::phase_t     phase;
  lprd_pkg::phase_t     phase_next;
  lprd_pkg::num_t       acc;
  lprd_pkg::num_t       acc_next;
  lprd_pkg::digit_cnt_t dig_cnt;
  lprd_pkg::digit_cnt_t dig_cnt_next;
  lprd_pkg::num_t       fields_left;
  lprd_pkg::num_t       fields_left_next;
  lprd_pkg::num_t       bytes_left;
  lprd_pkg::num_t       bytes_left_next;
  lprd_pkg::num_t       cur_field;
  lprd_pkg::num_t       cur_field_next;
  logic                 error_seen;
  logic                 error_seen_next;

  logic                 buf_full;
  logic                 go;
  logic                 eod;
  logic [7:0]           b;
  logic                 is_lb;
  logic                 start;
  lprd_pkg::phase_t     eff_phase;
  lprd_pkg::num_t       acc_eff;
  lprd_pkg::digit_cnt_t dig_cnt_eff;
  lprd_pkg::num_t       cur_field_eff;
  logic                 is_delim;
  logic                 is_digit;
  logic [lprd_pkg::NUM_W+3:0] acc_wide;
  logic [lprd_pkg::NUM_W+3:0] prod;
  logic                 num_ovf;
  logic                 val_zero;
  logic                 len_over;
  logic                 fr_is1;
  logic                 br_is1;
  logic                 res_push;
  lprd_pkg::res_t       res;

  assign in_stream.ready = !buf_full;
  assign go    = in_stream.valid && in_stream.ready && !error_seen;
  assign eod   = in_stream.end_of_data;
  assign b     = in_stream.in_byte;
  assign is_lb = (b == lprd_pkg::CHAR_LF) || (b == lprd_pkg::CHAR_CR);

  // A non-break byte in idle opens a record and is parsed in the count phase.
  assign start         = (phase == lprd_pkg::PH_IDLE) && !is_lb;
  assign eff_phase     = start ? lprd_pkg::PH_COUNT : phase;
  assign acc_eff       = start ? '0 : acc;
  assign dig_cnt_eff   = start ? '0 : dig_cnt;
  assign cur_field_eff = start ? '0 : cur_field;

  assign is_delim = (eff_phase == lprd_pkg::PH_COUNT) ? (b == lprd_pkg::CHAR_PIPE)
                                                      : (b == lprd_pkg::CHAR_COLON);
  assign is_digit = (b >= lprd_pkg::CHAR_ZERO) && (b <= lprd_pkg::CHAR_NINE);

  // acc*10 + digit with four guard bits to see overflow
  assign acc_wide = {4'b0, acc_eff};
  assign prod     = (acc_wide << 3) + (acc_wide << 1)
                  + (lprd_pkg::NUM_W+4)'(b[3:0]);
  assign num_ovf  = (prod[lprd_pkg::NUM_W+3:lprd_pkg::NUM_W] != 4'd0)
                  || (dig_cnt_eff >= lprd_pkg::DIGIT_W'(lprd_pkg::MAX_DIGITS));

  assign val_zero = (acc_eff == '0);
  assign len_over = (acc_eff > max_field_length);
  assign fr_is1   = (fields_left == lprd_pkg::NUM_W'(1));
  assign br_is1   = (bytes_left == lprd_pkg::NUM_W'(1));

  always_comb begin : next_phase
    phase_next = phase;
    if (go && !eod && !(phase == lprd_pkg::PH_IDLE && is_lb)) begin
      phase_next = eff_phase;
      case (eff_phase)
        lprd_pkg::PH_COUNT: begin
          if (is_delim && dig_cnt_eff != '0) begin
            phase_next = val_zero ? lprd_pkg::PH_IDLE : lprd_pkg::PH_LENGTH;
          end
        end
        lprd_pkg::PH_LENGTH: begin
          if (is_delim && dig_cnt_eff != '0 && !len_over) begin
            if (!val_zero) begin
              phase_next = lprd_pkg::PH_PAYLOAD;
            end else begin
              phase_next = fr_is1 ? lprd_pkg::PH_IDLE : lprd_pkg::PH_LENGTH;
            end
          end
        end
        lprd_pkg::PH_PAYLOAD: begin
          if (br_is1) begin
            phase_next = fr_is1 ? lprd_pkg::PH_IDLE : lprd_pkg::PH_LENGTH;
          end
        end
        default: begin
          phase_next = eff_phase;
        end
      endcase
    end
  end

  always_comb begin : datapath
    acc_next         = acc;
    dig_cnt_next     = dig_cnt;
    fields_left_next = fields_left;
    bytes_left_next  = bytes_left;
    cur_field_next   = cur_field;
    error_seen_next  = error_seen;
    res_push         = 1'b0;
    res              = '0;
    res.field_number = cur_field_eff;

    if (go) begin
      if (eod) begin
        if (phase != lprd_pkg::PH_IDLE) begin
          res_push        = 1'b1;
          res.kind        = lprd_pkg::KIND_ERROR;
          res.error_code  = lprd_pkg::ERR_TRUNC;
          error_seen_next = 1'b1;
        end
      end else if (!(phase == lprd_pkg::PH_IDLE && is_lb)) begin
        acc_next       = acc_eff;
        dig_cnt_next   = dig_cnt_eff;
        cur_field_next = cur_field_eff;
        case (eff_phase)
          lprd_pkg::PH_COUNT, lprd_pkg::PH_LENGTH: begin
            if (is_delim) begin
              acc_next     = '0;
              dig_cnt_next = '0;
              if (dig_cnt_eff == '0) begin
                res_push        = 1'b1;
                res.kind        = lprd_pkg::KIND_ERROR;
                res.error_code  = lprd_pkg::ERR_EMPTY;
                error_seen_next = 1'b1;
              end else if (eff_phase == lprd_pkg::PH_COUNT) begin
                if (val_zero) begin
                  res_push           = 1'b1;
                  res.kind           = lprd_pkg::KIND_EMPTY_RECORD;
                  res.field_number   = '0;
                  res.last_of_record = 1'b1;
                end else begin
                  fields_left_next = acc_eff;
                  cur_field_next   = '0;
                end
              end else if (len_over) begin
                res_push        = 1'b1;
                res.kind        = lprd_pkg::KIND_ERROR;
                res.error_code  = lprd_pkg::ERR_LIMIT;
                error_seen_next = 1'b1;
              end else if (val_zero) begin
                res_push           = 1'b1;
                res.kind           = lprd_pkg::KIND_EMPTY_FIELD;
                res.last_of_field  = 1'b1;
                res.last_of_record = fr_is1;
                fields_left_next   = fields_left - lprd_pkg::NUM_W'(1);
                cur_field_next     = fr_is1 ? '0 : cur_field_eff + lprd_pkg::NUM_W'(1);
              end else begin
                bytes_left_next = acc_eff;
              end
            end else if (!is_digit) begin
              res_push        = 1'b1;
              res.kind        = lprd_pkg::KIND_ERROR;
              res.error_code  = lprd_pkg::ERR_BADCHAR;
              error_seen_next = 1'b1;
            end else if (num_ovf) begin
              res_push        = 1'b1;
              res.kind        = lprd_pkg::KIND_ERROR;
              res.error_code  = lprd_pkg::ERR_OVERFLOW;
              error_seen_next = 1'b1;
            end else begin
              acc_next     = prod[lprd_pkg::NUM_W-1:0];
              dig_cnt_next = dig_cnt_eff + lprd_pkg::DIGIT_W'(1);
            end
          end
          lprd_pkg::PH_PAYLOAD: begin
            res_push           = 1'b1;
            res.kind           = lprd_pkg::KIND_BYTE;
            res.out_byte       = b;
            res.last_of_field  = br_is1;
            res.last_of_record = br_is1 && fr_is1;
            bytes_left_next    = bytes_left - lprd_pkg::NUM_W'(1);
            if (br_is1) begin
              fields_left_next = fields_left - lprd_pkg::NUM_W'(1);
              cur_field_next   = fr_is1 ? '0 : cur_field_eff + lprd_pkg::NUM_W'(1);
              acc_next         = '0;
              dig_cnt_next     = '0;
            end
          end
          default: begin
            res_push = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_field_length <= '1;
      phase            <= lprd_pkg::PH_IDLE;
      acc              <= '0;
      dig_cnt          <= '0;
      fields_left      <= '0;
      bytes_left       <= '0;
      cur_field        <= '0;
      error_seen       <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_field_length <= cfg_wdata;
      end
      phase       <= phase_next;
      acc         <= acc_next;
      dig_cnt     <= dig_cnt_next;
      fields_left <= fields_left_next;
      bytes_left  <= bytes_left_next;
      cur_field   <= cur_field_next;
      error_seen  <= error_seen_next;
    end
  end

  lprd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_push),
    .push_data  (res),
    .full       (buf_full),
    .out_stream (out_stream)
  );

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_seen |=> error_seen) else $error("error flag cleared without reset");

  a_silent_after_error: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> !res_push) else $error("result produced after error");

  a_error_sets_flag: assert property (@(posedge clk) disable iff (rst)
    res_push && res.kind == lprd_pkg::KIND_ERROR |=> error_seen)
    else $error("error result without sticky flag");

  a_digits_bounded: assert property (@(posedge clk) disable iff (rst)
    dig_cnt <= lprd_pkg::DIGIT_W'(lprd_pkg::MAX_DIGITS)) else $error("digit count overrun");

endmodule
